// File: hdl/pvwi_pkg.sv
// ============================================================================
// pvwi_pkg
// Shared types, constants and the arctangent table for the polar velocity
// wrap integrator.
// ============================================================================
`default_nettype none

package pvwi_pkg;

    // pipeline geometry
    localparam int CORDIC_STAGES = 16;
    localparam int STG_W         = $clog2(CORDIC_STAGES);
    localparam int POS_FRAC_BITS = 8;

    // angle and vector formats
    localparam logic [16:0] FULL_TURN    = 17'd92160;
    localparam logic [16:0] QUARTER_TURN = 17'd23040;
    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

    // reciprocals: floor(m/92160) = (m*RECIP_TURN)>>48, floor(n/125) = (n*RECIP_125)>>38
    localparam logic [31:0] RECIP_TURN = 32'd3054198967;
    localparam logic [31:0] RECIP_125  = 32'd2199023256;
    localparam logic [37:0] DIV125_CLAMP = 38'd2097152000;   // 125 * 2^24

    localparam logic [23:0] VEL_MAX = 24'd16777215;

    // configuration register indexes
    localparam logic REG_VIEW_WIDTH  = 1'b0;
    localparam logic REG_VIEW_HEIGHT = 1'b1;

    // fields that ride along the pipeline
    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [20:0] center_x;
        logic signed [20:0] center_y;
        logic        [19:0] box_width;
        logic        [19:0] box_height;
        logic        [23:0] speed;
        logic        [15:0] elapsed_ms;
        logic        [16:0] heading_norm;
        logic        [1:0]  quad;
    } t_carry;

    // one beat between rotation cells
    typedef struct packed {
        logic               vld;
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [31:0] z;
        t_carry             c;
    } t_cord;

    // atan(2^-i) in 2^-22 degree
    function automatic logic signed [31:0] atan_val(input logic [STG_W-1:0] i);
        logic signed [31:0] v;
        case (5'(i))
            5'd0:  v = 32'sd188743680;
            5'd1:  v = 32'sd111421900;
            5'd2:  v = 32'sd58872272;
            5'd3:  v = 32'sd29884485;
            5'd4:  v = 32'sd15000234;
            5'd5:  v = 32'sd7507429;
            5'd6:  v = 32'sd3754631;
            5'd7:  v = 32'sd1877430;
            5'd8:  v = 32'sd938729;
            5'd9:  v = 32'sd469366;
            5'd10: v = 32'sd234683;
            5'd11: v = 32'sd117342;
            5'd12: v = 32'sd58671;
            5'd13: v = 32'sd29335;
            5'd14: v = 32'sd14668;
            5'd15: v = 32'sd7334;
            5'd16: v = 32'sd3667;
            5'd17: v = 32'sd1833;
            5'd18: v = 32'sd917;
            5'd19: v = 32'sd458;
            5'd20: v = 32'sd229;
            5'd21: v = 32'sd115;
            5'd22: v = 32'sd57;
            5'd23: v = 32'sd29;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: hdl/polar_velocity_wrap_integrator.sv
// ============================================================================
// polar_velocity_wrap_integrator
// Heading normalization, CORDIC velocity, position integration and wrap.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one entity per beat:
//   position, center offset, box margins, speed, heading and elapsed time.
//   Output channel (o_out_valid / i_out_stall) returns the wrapped position,
//   normalized heading and Cartesian velocity, one beat per input beat.
//   Throughput is one beat per cycle while the receiver does not stall.
//   The pipeline has three normalize stages, one cell per rotation step,
//   then velocity, integration and two wrap stages.
//   The whole pipeline advances together; when the receiver stalls a valid
//   result, every stage holds and o_in_stall is raised in the same cycle.
//   Viewport width and height are written through i_cfg_we / i_cfg_idx /
//   i_cfg_data while idle; they reset to 640 and 480 pixels.
//   Reset is synchronous, active low, and clears every stage valid.
// ============================================================================
`default_nettype none

module polar_velocity_wrap_integrator (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_idx,
    input  wire logic [11:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic signed [23:0] i_pos_x,
    input  wire logic signed [23:0] i_pos_y,
    input  wire logic signed [20:0] i_center_x,
    input  wire logic signed [20:0] i_center_y,
    input  wire logic [19:0]        i_box_width,
    input  wire logic [19:0]        i_box_height,
    input  wire logic [23:0]        i_speed,
    input  wire logic signed [31:0] i_heading,
    input  wire logic [15:0]        i_elapsed_ms,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [23:0]      o_new_x,
    output logic signed [23:0]      o_new_y,
    output logic [16:0]             o_heading_norm,
    output logic signed [24:0]      o_vel_x,
    output logic signed [24:0]      o_vel_y
);
    import pvwi_pkg::*;

    logic [11:0] r_view_width, r_view_height;
    logic        w_en;
    t_carry      w_c;
    t_cord       w_chain [CORDIC_STAGES+1];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_width  <= 12'd640;
            r_view_height <= 12'd480;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_VIEW_WIDTH:  r_view_width  <= i_cfg_data;
                REG_VIEW_HEIGHT: r_view_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // global advance
    assign w_en       = !(o_out_valid && i_out_stall);
    assign o_in_stall = !w_en;

    always_comb begin
        w_c.pos_x        = i_pos_x;
        w_c.pos_y        = i_pos_y;
        w_c.center_x     = i_center_x;
        w_c.center_y     = i_center_y;
        w_c.box_width    = i_box_width;
        w_c.box_height   = i_box_height;
        w_c.speed        = i_speed;
        w_c.elapsed_ms   = i_elapsed_ms;
        w_c.heading_norm = '0;
        w_c.quad         = '0;
    end

    pvwi_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_vld     (i_in_valid),
        .i_heading (i_heading),
        .i_c       (w_c),
        .o_q       (w_chain[0])
    );

    // rotation cells
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        pvwi_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stage (STG_W'(g)),
            .i_d     (w_chain[g]),
            .o_q     (w_chain[g+1])
        );
    end

    pvwi_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_d            (w_chain[CORDIC_STAGES]),
        .i_view_width   (r_view_width),
        .i_view_height  (r_view_height),
        .o_vld          (o_out_valid),
        .o_new_x        (o_new_x),
        .o_new_y        (o_new_y),
        .o_heading_norm (o_heading_norm),
        .o_vel_x        (o_vel_x),
        .o_vel_y        (o_vel_y)
    );

    // checks
    a_stall_only_on_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_heading_norm <= FULL_TURN))
        else $error("heading out of range");

    a_vel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_vel_x != -25'sd16777216 && o_vel_y != -25'sd16777216))
        else $error("velocity beyond saturation");

endmodule

`default_nettype wire

// File: hdl/pvwi_front.sv
// ============================================================================
// pvwi_front
// Heading normalization and quadrant split, three register stages.
// ============================================================================
`default_nettype none

module pvwi_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_vld,
    input  wire logic signed [31:0]   i_heading,
    input  wire pvwi_pkg::t_carry     i_c,
    output pvwi_pkg::t_cord           o_q
);
    import pvwi_pkg::*;

    logic        r_a_vld, r_b_vld, r_c_vld;
    logic [31:0] r_a_mag, r_b_mag;
    logic        r_a_neg, r_b_neg;
    logic [14:0] r_b_q;
    t_carry      r_a_c, r_b_c;
    logic signed [31:0] r_c_z;
    t_carry      r_c_c;

    logic [63:0] w_prod;
    logic [31:0] w_r32;
    logic [16:0] w_rr, w_hn, w_rem;
    logic [1:0]  w_quad;
    t_carry      w_hc;

    // quotient estimate by reciprocal
    assign w_prod = 64'(r_a_mag) * 64'(RECIP_TURN);

    // remainder, sign fix and quadrant
    always_comb begin
        w_r32 = r_b_mag - 32'(r_b_q) * 32'(FULL_TURN);
        w_rr  = (r_b_mag > 32'(FULL_TURN)) ? w_r32[16:0] : r_b_mag[16:0];
        if (r_b_neg) begin
            w_hn = (w_rr == 17'd0) ? 17'd0 : FULL_TURN - w_rr;
        end else begin
            w_hn = w_rr;
        end
        if (w_hn == FULL_TURN) begin
            w_quad = 2'd0;
            w_rem  = 17'd0;
        end else if (w_hn >= 17'(3 * QUARTER_TURN)) begin
            w_quad = 2'd3;
            w_rem  = w_hn - 17'(3 * QUARTER_TURN);
        end else if (w_hn >= 17'(2 * QUARTER_TURN)) begin
            w_quad = 2'd2;
            w_rem  = w_hn - 17'(2 * QUARTER_TURN);
        end else if (w_hn >= QUARTER_TURN) begin
            w_quad = 2'd1;
            w_rem  = w_hn - QUARTER_TURN;
        end else begin
            w_quad = 2'd0;
            w_rem  = w_hn;
        end
        w_hc              = r_b_c;
        w_hc.heading_norm = w_hn;
        w_hc.quad         = w_quad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_mag <= i_heading[31] ? 32'(-i_heading) : 32'(i_heading);
            r_a_neg <= i_heading[31];
            r_a_c   <= i_c;
            r_b_mag <= r_a_mag;
            r_b_neg <= r_a_neg;
            r_b_q   <= w_prod[62:48];
            r_b_c   <= r_a_c;
            r_c_z   <= $signed({1'b0, w_rem[14:0], 14'd0, 2'b00} >> 2);
            r_c_c   <= w_hc;
        end
    end

    // vector starts at (K, 0)
    always_comb begin
        o_q.vld = r_c_vld;
        o_q.x   = CORDIC_GAIN;
        o_q.y   = 33'sd0;
        o_q.z   = r_c_z;
        o_q.c   = r_c_c;
    end

endmodule

`default_nettype wire

// File: hdl/pvwi_cordic_cell.sv
// ============================================================================
// pvwi_cordic_cell
// One rotation step of the sine/cosine chain, registered.
// ============================================================================
`default_nettype none

module pvwi_cordic_cell (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic [pvwi_pkg::STG_W-1:0]    i_stage,
    input  wire pvwi_pkg::t_cord               i_d,
    output pvwi_pkg::t_cord                    o_q
);
    import pvwi_pkg::*;

    t_cord r_q;
    t_cord n_q;
    logic signed [32:0] w_dx, w_dy;
    logic signed [31:0] w_at;

    // rotate toward zero residual angle
    always_comb begin
        w_dx = i_d.y >>> i_stage;
        w_dy = i_d.x >>> i_stage;
        w_at = atan_val(i_stage);
        n_q  = i_d;
        if (i_d.z >= 0) begin
            n_q.x = i_d.x - w_dx;
            n_q.y = i_d.y + w_dy;
            n_q.z = i_d.z - w_at;
        end else begin
            n_q.x = i_d.x + w_dx;
            n_q.y = i_d.y - w_dy;
            n_q.z = i_d.z + w_at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.vld <= 1'b0;
        end else if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

// File: hdl/pvwi_back.sv
// ============================================================================
// pvwi_back
// Velocity scaling, position integration, saturation and viewport wrap.
// ============================================================================
`default_nettype none

module pvwi_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire pvwi_pkg::t_cord      i_d,
    input  wire logic [11:0]          i_view_width,
    input  wire logic [11:0]          i_view_height,
    output logic                      o_vld,
    output logic signed [23:0]        o_new_x,
    output logic signed [23:0]        o_new_y,
    output logic [16:0]               o_heading_norm,
    output logic signed [24:0]        o_vel_x,
    output logic signed [24:0]        o_vel_y
);
    import pvwi_pkg::*;

    // stage valids: P V D N I W1 W2
    logic [6:0] r_vld;

    // P: trig times speed
    logic [55:0] r_p_px, r_p_py;
    logic        r_p_nx, r_p_ny;
    t_carry      r_p_c;
    // V: rounded velocity
    logic signed [24:0] r_v_vx, r_v_vy;
    logic [23:0] r_v_mx, r_v_my;
    logic        r_v_nx, r_v_ny;
    t_carry      r_v_c;
    // D: velocity times elapsed
    logic [39:0] r_d_px, r_d_py;
    logic signed [24:0] r_d_vx, r_d_vy;
    logic        r_d_nx, r_d_ny;
    t_carry      r_d_c;
    // N: divide by 125 product
    logic [62:0] r_n_px, r_n_py;
    logic        r_n_kx, r_n_ky, r_n_nx, r_n_ny;
    logic signed [24:0] r_n_vx, r_n_vy;
    t_carry      r_n_c;
    // I: integrated position
    logic signed [23:0] r_i_x, r_i_y;
    logic signed [24:0] r_i_vx, r_i_vy;
    t_carry      r_i_c;
    // W1: first wrap test
    logic signed [23:0] r_w_x, r_w_y;
    logic signed [24:0] r_w_vx, r_w_vy;
    t_carry      r_w_c;

    // P stage logic
    logic signed [32:0] w_sn, w_cs;
    logic [31:0] w_msn, w_mcs;
    always_comb begin
        case (i_d.c.quad)
            2'd0:    begin w_sn = i_d.y;  w_cs = i_d.x;  end
            2'd1:    begin w_sn = i_d.x;  w_cs = -i_d.y; end
            2'd2:    begin w_sn = -i_d.y; w_cs = -i_d.x; end
            default: begin w_sn = -i_d.x; w_cs = i_d.y;  end
        endcase
        w_msn = w_sn[32] ? 32'(-w_sn) : 32'(w_sn);
        w_mcs = w_cs[32] ? 32'(-w_cs) : 32'(w_cs);
    end

    // V stage: round to nearest, saturate
    logic [26:0] w_qx, w_qy;
    logic [23:0] w_mx, w_my;
    assign w_qx = 27'((r_p_px + 56'd536870912) >> 30);
    assign w_qy = 27'((r_p_py + 56'd536870912) >> 30);
    assign w_mx = (w_qx > 27'(VEL_MAX)) ? VEL_MAX : w_qx[23:0];
    assign w_my = (w_qy > 27'(VEL_MAX)) ? VEL_MAX : w_qy[23:0];

    // N stage: (m+500)/8, clamp at 2^24 quotient, reciprocal of 125
    logic [37:0] w_nx, w_ny;
    assign w_nx = 38'((41'(r_d_px) + 41'd500) >> 3);
    assign w_ny = 38'((41'(r_d_py) + 41'd500) >> 3);

    // I stage: apply delta and saturate
    logic [24:0] w_dqx, w_dqy;
    logic signed [26:0] w_sx, w_sy;
    assign w_dqx = r_n_kx ? 25'h1000000 : r_n_px[62:38];
    assign w_dqy = r_n_ky ? 25'h1000000 : r_n_py[62:38];
    assign w_sx = 27'(r_n_c.pos_x) + (r_n_nx ? -27'(w_dqx) : 27'(w_dqx));
    assign w_sy = 27'(r_n_c.pos_y) + (r_n_ny ? -27'(w_dqy) : 27'(w_dqy));

    function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
        logic signed [23:0] s;
        if (v > 28'sd8388607) begin
            s = 24'sd8388607;
        end else if (v < -28'sd8388608) begin
            s = -24'sd8388608;
        end else begin
            s = v[23:0];
        end
        return s;
    endfunction

    // viewport limits in position units
    logic signed [27:0] w_wl, w_hl;
    assign w_wl = 28'({i_view_width,  {POS_FRAC_BITS{1'b0}}});
    assign w_hl = 28'({i_view_height, {POS_FRAC_BITS{1'b0}}});

    // W1: right and bottom edges
    logic signed [23:0] w_w1x, w_w1y;
    always_comb begin
        w_w1x = r_i_x;
        w_w1y = r_i_y;
        if (28'(r_i_x) + 28'(r_i_c.center_x) >
            w_wl + $signed(28'(r_i_c.box_width))) begin
            w_w1x = -24'(r_i_c.box_width);
        end
        if (28'(r_i_y) + 28'(r_i_c.center_y) >
            w_hl + $signed(28'(r_i_c.box_height))) begin
            w_w1y = -24'(r_i_c.box_height);
        end
    end

    // W2: left and top edges, final saturation
    logic signed [27:0] w_w2x, w_w2y;
    always_comb begin
        w_w2x = 28'(r_w_x);
        w_w2y = 28'(r_w_y);
        if (28'(r_w_x) + 28'(r_w_c.center_x) < -$signed(28'(r_w_c.box_width))) begin
            w_w2x = w_wl;
        end
        if (28'(r_w_y) + 28'(r_w_c.center_y) < -$signed(28'(r_w_c.box_height))) begin
            w_w2y = w_hl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[5:0], i_d.vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_px <= 56'(i_d.c.speed) * 56'(w_msn);
            r_p_py <= 56'(i_d.c.speed) * 56'(w_mcs);
            r_p_nx <= w_sn[32];
            r_p_ny <= (w_cs > 0);
            r_p_c  <= i_d.c;

            r_v_mx <= w_mx;
            r_v_my <= w_my;
            r_v_vx <= r_p_nx ? -25'(w_mx) : 25'(w_mx);
            r_v_vy <= r_p_ny ? -25'(w_my) : 25'(w_my);
            r_v_nx <= r_p_nx;
            r_v_ny <= r_p_ny;
            r_v_c  <= r_p_c;

            r_d_px <= 40'(r_v_mx) * 40'(r_v_c.elapsed_ms);
            r_d_py <= 40'(r_v_my) * 40'(r_v_c.elapsed_ms);
            r_d_vx <= r_v_vx;
            r_d_vy <= r_v_vy;
            r_d_nx <= r_v_nx;
            r_d_ny <= r_v_ny;
            r_d_c  <= r_v_c;

            r_n_px <= 63'(w_nx[30:0]) * 63'(RECIP_125);
            r_n_py <= 63'(w_ny[30:0]) * 63'(RECIP_125);
            r_n_kx <= (w_nx >= DIV125_CLAMP);
            r_n_ky <= (w_ny >= DIV125_CLAMP);
            r_n_nx <= r_d_nx;
            r_n_ny <= r_d_ny;
            r_n_vx <= r_d_vx;
            r_n_vy <= r_d_vy;
            r_n_c  <= r_d_c;

            r_i_x  <= sat24(28'(w_sx));
            r_i_y  <= sat24(28'(w_sy));
            r_i_vx <= r_n_vx;
            r_i_vy <= r_n_vy;
            r_i_c  <= r_n_c;

            r_w_x  <= w_w1x;
            r_w_y  <= w_w1y;
            r_w_vx <= r_i_vx;
            r_w_vy <= r_i_vy;
            r_w_c  <= r_i_c;

            o_new_x        <= sat24(w_w2x);
            o_new_y        <= sat24(w_w2y);
            o_heading_norm <= r_w_c.heading_norm;
            o_vel_x        <= r_w_vx;
            o_vel_y        <= r_w_vy;
        end
    end

    assign o_vld = r_vld[6];

endmodule

`default_nettype wire

// File: tb/pvwi_checker.sv
// ============================================================================
// pvwi_checker
// Watches both channels of the polar velocity wrap integrator, computes the
// expected position, heading and velocity for every accepted entity beat and
// compares each result beat with the oldest expectation.
// ============================================================================
`default_nettype none

module pvwi_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_idx,
    input  wire logic [11:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_stall,
    input  wire logic signed [23:0] i_pos_x,
    input  wire logic signed [23:0] i_pos_y,
    input  wire logic signed [20:0] i_center_x,
    input  wire logic signed [20:0] i_center_y,
    input  wire logic [19:0]        i_box_width,
    input  wire logic [19:0]        i_box_height,
    input  wire logic [23:0]        i_speed,
    input  wire logic signed [31:0] i_heading,
    input  wire logic [15:0]        i_elapsed_ms,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire logic signed [23:0] i_new_x,
    input  wire logic signed [23:0] i_new_y,
    input  wire logic [16:0]        i_heading_norm,
    input  wire logic signed [24:0] i_vel_x,
    input  wire logic signed [24:0] i_vel_y,
    output int                      o_fail_cnt,
    output int                      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import pvwi_pkg::*;

    typedef struct packed {
        logic signed [23:0] new_x;
        logic signed [23:0] new_y;
        logic        [16:0] heading_norm;
        logic signed [24:0] vel_x;
        logic signed [24:0] vel_y;
    } t_motion;

    t_motion     motion_q[$];
    logic [11:0] view_w;
    logic [11:0] view_h;
    int          report_cnt;

    function automatic longint asr64(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_div(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q   = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint atan_step(int i);
        longint tab[24] = '{188743680, 111421900, 58872272, 29884485, 15000234,
                            7507429, 3754631, 1877430, 938729, 469366, 234683,
                            117342, 58671, 29335, 14668, 7334, 3667, 1833, 917,
                            458, 229, 115, 57, 29};
        return tab[i];
    endfunction

    function automatic t_motion predict_motion(
        longint px, longint py, longint cx, longint cy, longint bw, longint bh,
        longint spd, longint hd, longint el, longint vw, longint vh);
        t_motion m;
        longint  fw, fh, quad, rem, cx_v, sy_v, z, dx, dy, sn, cs, vx, vy;
        fw = vw << POS_FRAC_BITS;
        fh = vh << POS_FRAC_BITS;
        // heading into 0..360 degrees
        if (hd > 92160 || hd < -92160) hd = hd % 92160;
        if (hd < 0) hd += 92160;
        quad = (hd / 23040) & 3;
        rem  = hd % 23040;
        // rotation-mode CORDIC on the in-quadrant angle
        cx_v = 652032874;
        sy_v = 0;
        z    = rem << 14;
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
            dx = asr64(sy_v, i);
            dy = asr64(cx_v, i);
            if (z >= 0) begin
                cx_v -= dx; sy_v += dy; z -= atan_step(i);
            end else begin
                cx_v += dx; sy_v -= dy; z += atan_step(i);
            end
        end
        case (quad)
            0: begin sn = sy_v;  cs = cx_v;  end
            1: begin sn = cx_v;  cs = -sy_v; end
            2: begin sn = -sy_v; cs = -cx_v; end
            default: begin sn = -cx_v; cs = sy_v; end
        endcase
        vx = clamp(round_div(spd * sn, 64'sd1 << 30), -16777215, 16777215);
        vy = clamp(round_div(-(spd * cs), 64'sd1 << 30), -16777215, 16777215);
        px = clamp(px + round_div(vx * el, 1000), -8388608, 8388607);
        py = clamp(py + round_div(vy * el, 1000), -8388608, 8388607);
        // wrap tests, each seeing the one before
        if (px + cx > fw + bw) px = -bw;
        if (px + cx < -bw)     px = fw;
        if (py + cy > fh + bh) py = -bh;
        if (py + cy < -bh)     py = fh;
        m.new_x        = 24'(clamp(px, -8388608, 8388607));
        m.new_y        = 24'(clamp(py, -8388608, 8388607));
        m.heading_norm = 17'(hd);
        m.vel_x        = 25'(vx);
        m.vel_y        = 25'(vy);
        return m;
    endfunction

    assign o_pending = motion_q.size();

    always @(posedge i_clk) begin
        t_motion got;
        t_motion exp_m;
        if (!i_rst_n) begin
            view_w     <= 12'd640;
            view_h     <= 12'd480;
            o_fail_cnt <= 0;
            report_cnt = 0;
            motion_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_VIEW_WIDTH) view_w <= i_cfg_data;
                else view_h <= i_cfg_data;
            end
            // expectation for each accepted entity beat
            if (i_in_valid && !i_in_stall)
                motion_q.push_back(predict_motion(i_pos_x, i_pos_y, i_center_x,
                    i_center_y, i_box_width, i_box_height, i_speed, i_heading,
                    i_elapsed_ms, view_w, view_h));
            // compare result beats in order
            if (i_out_valid && !i_out_stall) begin
                got = '{i_new_x, i_new_y, i_heading_norm, i_vel_x, i_vel_y};
                if (motion_q.size() == 0) begin
                    o_fail_cnt <= o_fail_cnt + 1;
                    if (report_cnt < 10)
                        $display("unexpected result beat: %p", got);
                    report_cnt++;
                end else begin
                    exp_m = motion_q.pop_front();
                    if (got !== exp_m) begin
                        o_fail_cnt <= o_fail_cnt + 1;
                        if (report_cnt < 10)
                            $display("mismatch at %0t: exp %p got %p",
                                     $time, exp_m, got);
                        report_cnt++;
                    end
                end
            end
        end
    end
endmodule

`default_nettype wire

// File: tb/tb_polar_velocity_wrap_integrator.sv
// ============================================================================
// tb_polar_velocity_wrap_integrator
// Drives entity beats through the integrator under several idle and stall
// mixes and viewport settings; the checker predicts and compares every result.
// ============================================================================
`default_nettype none

module tb_polar_velocity_wrap_integrator;
    timeunit 1ns;
    timeprecision 1ps;
    import pvwi_pkg::*;

    localparam int LATENCY = 3 + CORDIC_STAGES + 7;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic               cfg_idx = REG_VIEW_WIDTH;
    logic [11:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [23:0] pos_x = '0, pos_y = '0;
    logic signed [20:0] center_x = '0, center_y = '0;
    logic [19:0]        box_width = '0, box_height = '0;
    logic [23:0]        speed = '0;
    logic signed [31:0] heading = '0;
    logic [15:0]        elapsed_ms = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [23:0] new_x, new_y;
    logic [16:0]        heading_norm;
    logic signed [24:0] vel_x, vel_y;
    int                 fail_cnt;
    int                 pending;
    int                 send_idle_pct = 0;
    int                 stall_pct = 0;
    int                 hold_cycles = 0;

    always #5 clk = ~clk;

    polar_velocity_wrap_integrator u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_pos_x(pos_x), .i_pos_y(pos_y), .i_center_x(center_x),
        .i_center_y(center_y), .i_box_width(box_width), .i_box_height(box_height),
        .i_speed(speed), .i_heading(heading), .i_elapsed_ms(elapsed_ms),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_new_x(new_x), .o_new_y(new_y), .o_heading_norm(heading_norm),
        .o_vel_x(vel_x), .o_vel_y(vel_y)
    );

    pvwi_checker u_chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_pos_x(pos_x), .i_pos_y(pos_y), .i_center_x(center_x),
        .i_center_y(center_y), .i_box_width(box_width), .i_box_height(box_height),
        .i_speed(speed), .i_heading(heading), .i_elapsed_ms(elapsed_ms),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_new_x(new_x), .i_new_y(new_y), .i_heading_norm(heading_norm),
        .i_vel_x(vel_x), .i_vel_y(vel_y),
        .o_fail_cnt(fail_cnt), .o_pending(pending)
    );

    // receiver stall: random mix, or a long counted hold-off
    always @(posedge clk) begin
        if (hold_cycles > 0) begin
            out_stall   <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // one entity beat; held until accepted, valid left high for the next one
    task automatic send_entity(input logic [23:0] px, input logic [23:0] py,
                               input logic [20:0] cx, input logic [20:0] cy,
                               input logic [19:0] bw, input logic [19:0] bh,
                               input logic [23:0] spd, input logic [31:0] hd,
                               input logic [15:0] el);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        pos_x <= px; pos_y <= py; center_x <= cx; center_y <= cy;
        box_width <= bw; box_height <= bh; speed <= spd; heading <= hd;
        elapsed_ms <= el; in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_random;
        logic [31:0] hd;
        logic [23:0] px, py;
        logic [19:0] bw, bh;
        logic [20:0] cx, cy;
        int          pick;
        pick = $urandom_range(9);
        case (pick)
            0: hd = $urandom;
            1: hd = 32'($signed($urandom_range(8 * 92160)) - 4 * 92160);
            2: hd = 32'(23040 * $urandom_range(8)) - 32'(92160 * 2) + $urandom_range(2) - 1;
            default: hd = $urandom_range(92160);
        endcase
        // mostly positions near the viewport so wraps fire both ways
        if ($urandom_range(3) == 0) begin
            px = 24'($urandom); py = 24'($urandom);
            bw = 20'($urandom); bh = 20'($urandom);
            cx = 21'($urandom); cy = 21'($urandom);
        end else begin
            px = 24'($signed($urandom_range(200000)) - 30000);
            py = 24'($signed($urandom_range(160000)) - 30000);
            bw = 20'($urandom_range(8000)); bh = 20'($urandom_range(8000));
            cx = 21'($signed($urandom_range(8000)) - 4000);
            cy = 21'($signed($urandom_range(8000)) - 4000);
        end
        send_entity(px, py, cx, cy, bw, bh,
                    ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(20000)),
                    hd, ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(100)));
    endtask

    task automatic wait_drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_view(input logic idx, input logic [11:0] val);
        cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, quadrant edges, heading normalization, wrap edges
        send_entity(24'h000000, 24'h000000, '0, '0, '0, '0, '0, 32'sd0, '0);
        send_entity(24'h7FFFFF, 24'h7FFFFF, 21'h0FFFFF, 21'h0FFFFF,
                    20'hFFFFF, 20'hFFFFF, 24'hFFFFFF, 32'h7FFFFFFF, 16'hFFFF);
        send_entity(24'h800000, 24'h800000, 21'h100000, 21'h100000,
                    '0, '0, 24'hFFFFFF, 32'h80000000, 16'hFFFF);
        send_entity(24'd1000, 24'd1000, '0, '0, 20'd10, 20'd10, 24'hFFFFFF, 32'sd92160, 16'hFFFF);
        send_entity(24'd1000, 24'd1000, '0, '0, 20'd10, 20'd10, 24'hFFFFFF, -32'sd92160, 16'd1000);
        send_entity(24'd5000, 24'd5000, '0, '0, '0, '0, 24'd256000, 32'sd92161, 16'd500);
        send_entity(24'd5000, 24'd5000, '0, '0, '0, '0, 24'd256000, -32'sd92161, 16'd500);
        send_entity(24'd5000, 24'd5000, '0, '0, '0, '0, 24'd256000, -32'sd1, 16'd500);
        for (int qd = 1; qd <= 3; qd++)
            send_entity(24'd9000, 24'd9000, '0, '0, '0, '0, 24'd100000,
                        32'(qd * 23040), 16'd100);
        send_entity(24'd163841, 24'd100, '0, '0, '0, '0, '0, '0, '0);
        send_entity(-24'sd1, 24'd100, '0, '0, '0, '0, '0, '0, '0);
        send_entity(24'd100, 24'd122881, '0, '0, '0, '0, '0, '0, '0);
        send_entity(24'd100, -24'sd1, '0, '0, '0, '0, '0, '0, '0);
        send_entity(24'd163840, 24'd122880, 21'd1, 21'd1, 20'd1, 20'd1, '0, '0, '0);
        wait_drain();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 79; stall_pct = 0;
                    write_view(REG_VIEW_WIDTH, 12'd0); write_view(REG_VIEW_HEIGHT, 12'hFFF); end
                2: begin send_idle_pct = 0;  stall_pct = 79;
                    write_view(REG_VIEW_WIDTH, 12'hFFF); write_view(REG_VIEW_HEIGHT, 12'd0); end
                3: begin send_idle_pct = 27; stall_pct = 27;
                    write_view(REG_VIEW_WIDTH, 12'($urandom));
                    write_view(REG_VIEW_HEIGHT, 12'($urandom)); end
                default: begin send_idle_pct = 0; stall_pct = 10;
                    write_view(REG_VIEW_WIDTH, 12'd640); write_view(REG_VIEW_HEIGHT, 12'd480); end
            endcase
            if (ph == 4) hold_cycles <= 200;  // fill the pipe while offering
            for (int n = 0; n < 330; n++) send_random();
            wait_drain();
        end

        if (fail_cnt == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule

`default_nettype wire

// File: files.f
hdl/pvwi_pkg.sv
hdl/pvwi_front.sv
hdl/pvwi_cordic_cell.sv
hdl/pvwi_back.sv
hdl/polar_velocity_wrap_integrator.sv
tb/pvwi_checker.sv
tb/tb_polar_velocity_wrap_integrator.sv
